/* sv/sjv_pkg.sv */
// package for the strict json validator: parse modes, error codes, byte classes
// no dependencies
`default_nettype none
package sjv_pkg;

  typedef enum logic [4:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER, M_DONE,
    M_STR, M_ESC, M_HEX, M_LIT, M_NEG, M_ZERO, M_INT, M_FRAC0, M_FRAC,
    M_EXP0, M_EXPS, M_EXP
  } mode_t;

  localparam logic [3:0] E_NONE     = 4'd0;
  localparam logic [3:0] E_BAD_BYTE = 4'd1;
  localparam logic [3:0] E_CTRL     = 4'd2;
  localparam logic [3:0] E_ESCAPE   = 4'd3;
  localparam logic [3:0] E_DEEP     = 4'd4;
  localparam logic [3:0] E_TOKENS   = 4'd5;
  localparam logic [3:0] E_TRUNC    = 4'd6;
  localparam logic [3:0] E_TRAIL    = 4'd7;
  localparam logic [3:0] E_NOT_OBJ  = 4'd8;
  localparam logic [3:0] E_LONG     = 4'd9;

  localparam logic [1:0] CFG_MAX_NESTING    = 2'd0;
  localparam logic [1:0] CFG_MAX_TOKENS     = 2'd1;
  localparam logic [1:0] CFG_REQUIRE_OBJECT = 2'd2;

  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ws;
    logic       digit;
    logic       digit19;
    logic       hex;
    logic       ctrl;
    logic       expch;
    logic       simple_esc;
  } cls_t;

  function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    case (sel)
      LIT_FALSE: begin
        case (k)
          3'd0: r = "f";
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          default: r = "e";
        endcase
      end
      LIT_NULL: begin
        case (k)
          3'd0: r = "n";
          3'd1: r = "u";
          3'd2: r = "l";
          default: r = "l";
        endcase
      end
      default: begin
        case (k)
          3'd0: r = "t";
          3'd1: r = "r";
          3'd2: r = "u";
          default: r = "e";
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] sel);
    return (sel == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage
`default_nettype wire

/* sv/sjv_if.sv */
// valid/ready stream interfaces for the byte input and result output
// depends on nothing
`default_nettype none
interface sjv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] doc_byte;
  logic       end_of_doc;
  modport source (output valid, doc_byte, end_of_doc, input ready);
  modport sink (input valid, doc_byte, end_of_doc, output ready);
endinterface

interface sjv_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  error_code;
  logic [20:0] error_offset;
  logic [15:0] token_count;
  modport source (output valid, accepted, error_code, error_offset, token_count,
                  input ready);
  modport sink (input valid, accepted, error_code, error_offset, token_count,
                output ready);
endinterface
`default_nettype wire

/* sv/sjv_front.sv */
// front: accepts bytes, classifies them and queues them for the parser
// depends on sjv_pkg
`default_nettype none
module sjv_front import sjv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [7:0] in_byte,
  input  wire logic in_last,
  input  wire logic in_valid,
  output logic      in_ready,
  output cls_t      q_data,
  output logic      q_valid,
  input  wire logic q_ready
);
  // two-entry queue
  cls_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cls_t       c;
  logic       push, pop;
  logic [7:0] b;

  always_comb begin
    b = in_byte;
    c.ch = b;
    c.last = in_last;
    c.ws = (b == " ") || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    c.digit = (b >= "0") && (b <= "9");
    c.digit19 = (b >= "1") && (b <= "9");
    c.hex = c.digit || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
    c.ctrl = b < 8'd32;
    c.expch = (b == "e") || (b == "E");
    c.simple_esc = (b == "\"") || (b == "\\") || (b == "/") || (b == "b") ||
                   (b == "f") || (b == "n") || (b == "r") || (b == "t");
  end

  assign in_ready = cnt_r != 2'd2;
  assign q_valid  = cnt_r != 2'd0;
  assign q_data   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* sv/sjv_back.sv */
// back: parser state machine, container stack and result register
// depends on sjv_pkg
`default_nettype none
module sjv_back import sjv_pkg::*; #(
  parameter int STACK_LEVELS  = 65,
  parameter int MAX_DOC_BYTES = 1048576,
  parameter int TOKEN_LIMIT   = 32768
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cls_t      q_data,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output logic      res_valid,
  input  wire logic res_ready,
  output logic      res_accepted,
  output logic [3:0] res_code,
  output logic [20:0] res_offset,
  output logic [15:0] res_tokens
);
  localparam int LW = $clog2(STACK_LEVELS + 1);
  localparam int SW = $clog2(STACK_LEVELS);
  localparam int OW = $clog2(MAX_DOC_BYTES + 1);
  localparam int TW = $clog2(TOKEN_LIMIT + 1);
  localparam logic [LW-1:0] NEST_CAP = LW'(STACK_LEVELS - 1);
  localparam logic [TW-1:0] TOK_CAP  = TW'(TOKEN_LIMIT);
  localparam logic [OW-1:0] OFF_MAX  = OW'(MAX_DOC_BYTES);

  logic [6:0]  max_nest_r;
  logic [15:0] max_tok_r;
  logic        req_obj_r;

  logic [STACK_LEVELS-1:0] stk_r, stk_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  mode_t         mode_r, mode_nxt;
  logic [2:0]    sub_r, sub_nxt;
  logic [1:0]    lsel_r, lsel_nxt;
  logic          key_r, key_nxt;
  logic [TW-1:0] tok_r, tok_nxt;
  logic [OW-1:0] off_r;
  logic [3:0]    err_r, err_nxt;
  logic [OW-1:0] eoff_r, eoff_nxt;

  logic [LW-1:0] nest_lim;
  logic [TW-1:0] tok_lim;
  logic          top_bit;
  logic          take;
  logic          complete;
  logic [7:0]    ch;

  always_comb begin
    nest_lim = (32'(max_nest_r) > 32'(NEST_CAP)) ? NEST_CAP : LW'(max_nest_r);
    tok_lim = (32'(max_tok_r) > 32'(TOK_CAP)) ? TOK_CAP : TW'(max_tok_r);
  end

  assign q_ready = !res_valid || res_ready;
  assign take    = q_valid && q_ready;
  assign ch      = q_data.ch;
  assign top_bit = (lvl_r != '0) ? stk_r[SW'(lvl_r - LW'(1))] : 1'b0;

  always_comb begin
    logic rerun;
    mode_t m;
    stk_nxt = stk_r; lvl_nxt = lvl_r; mode_nxt = mode_r; sub_nxt = sub_r;
    lsel_nxt = lsel_r; key_nxt = key_r; tok_nxt = tok_r;
    err_nxt = err_r; eoff_nxt = eoff_r;
    rerun = 1'b0; m = mode_r;
    if (err_r == E_NONE) begin
      if (off_r >= OFF_MAX) begin
        err_nxt = E_LONG; eoff_nxt = off_r;
      end else begin
        // a number ends on a delimiter, which is then parsed after the value end
        case (mode_r)
          M_ZERO, M_INT: begin
            if (!(mode_r == M_INT && q_data.digit) && ch != "." && !q_data.expch) rerun = 1'b1;
          end
          M_FRAC: if (!q_data.digit && !q_data.expch) rerun = 1'b1;
          M_EXP:  if (!q_data.digit) rerun = 1'b1;
          default: ;
        endcase
        if (rerun) m = (lvl_r != '0) ? M_AFTER : M_DONE;
        mode_nxt = m;
        case (m)
          M_VALUE, M_ARR_FIRST: begin
            if (q_data.ws) begin
            end else if (m == M_ARR_FIRST && ch == "]") begin
              if (lvl_r == '0 || top_bit) begin
                err_nxt = E_BAD_BYTE;
              end else begin
                lvl_nxt = lvl_r - LW'(1);
                mode_nxt = (lvl_nxt != '0) ? M_AFTER : M_DONE;
              end
            end else if (lvl_r > nest_lim) begin
              err_nxt = E_DEEP;
            end else if (tok_r >= tok_lim) begin
              err_nxt = E_TOKENS;
            end else if (!(ch == "{" || ch == "[" || ch == "\"" || ch == "t" ||
                           ch == "f" || ch == "n" || ch == "-" || q_data.digit)) begin
              err_nxt = E_BAD_BYTE;
            end else if (lvl_r == '0 && req_obj_r && ch != "{") begin
              err_nxt = E_NOT_OBJ;
            end else begin
              tok_nxt = tok_r + TW'(1);
              if (ch == "{" || ch == "[") begin
                stk_nxt[SW'(lvl_r)] = (ch == "{");
                lvl_nxt = lvl_r + LW'(1);
                mode_nxt = (ch == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
              end else if (ch == "\"") begin
                key_nxt = 1'b0; mode_nxt = M_STR;
              end else if (ch == "t" || ch == "f" || ch == "n") begin
                lsel_nxt = (ch == "t") ? LIT_TRUE : (ch == "f") ? LIT_FALSE : LIT_NULL;
                sub_nxt = 3'd1; mode_nxt = M_LIT;
              end else if (ch == "-") mode_nxt = M_NEG;
              else if (ch == "0") mode_nxt = M_ZERO;
              else mode_nxt = M_INT;
            end
          end
          M_OBJ_FIRST, M_KEY: begin
            if (q_data.ws) begin
            end else if (ch == "}" && m == M_OBJ_FIRST) begin
              if (lvl_r == '0 || !top_bit) err_nxt = E_BAD_BYTE;
              else begin
                lvl_nxt = lvl_r - LW'(1);
                mode_nxt = (lvl_nxt != '0) ? M_AFTER : M_DONE;
              end
            end else if (ch == "\"") begin
              if (lvl_r > nest_lim) err_nxt = E_DEEP;
              else if (tok_r >= tok_lim) err_nxt = E_TOKENS;
              else begin
                tok_nxt = tok_r + TW'(1); key_nxt = 1'b1; mode_nxt = M_STR;
              end
            end else err_nxt = E_BAD_BYTE;
          end
          M_COLON: begin
            if (q_data.ws) begin
            end else if (ch == ":") mode_nxt = M_VALUE;
            else err_nxt = E_BAD_BYTE;
          end
          M_AFTER: begin
            if (q_data.ws) begin
            end else if (ch == "," && lvl_r != '0) begin
              mode_nxt = top_bit ? M_KEY : M_VALUE;
            end else if (ch == "}" || ch == "]") begin
              if (lvl_r == '0 || top_bit != (ch == "}")) err_nxt = E_BAD_BYTE;
              else begin
                lvl_nxt = lvl_r - LW'(1);
                mode_nxt = (lvl_nxt != '0) ? M_AFTER : M_DONE;
              end
            end else err_nxt = E_BAD_BYTE;
          end
          M_DONE: if (!q_data.ws) err_nxt = E_TRAIL;
          M_STR: begin
            if (q_data.ctrl) err_nxt = E_CTRL;
            else if (ch == "\"") mode_nxt = key_r ? M_COLON : ((lvl_r != '0) ? M_AFTER : M_DONE);
            else if (ch == "\\") mode_nxt = M_ESC;
          end
          M_ESC: begin
            if (ch == "u") begin sub_nxt = 3'd0; mode_nxt = M_HEX; end
            else if (q_data.simple_esc) mode_nxt = M_STR;
            else err_nxt = E_ESCAPE;
          end
          M_HEX: begin
            if (!q_data.hex) err_nxt = E_ESCAPE;
            else begin
              sub_nxt = sub_r + 3'd1;
              if (sub_nxt >= 3'd4) mode_nxt = M_STR;
            end
          end
          M_LIT: begin
            if (ch != lit_char(lsel_r, sub_r)) err_nxt = E_BAD_BYTE;
            else begin
              sub_nxt = sub_r + 3'd1;
              if (sub_nxt >= lit_len(lsel_r)) mode_nxt = (lvl_r != '0) ? M_AFTER : M_DONE;
            end
          end
          M_NEG: begin
            if (ch == "0") mode_nxt = M_ZERO;
            else if (q_data.digit19) mode_nxt = M_INT;
            else err_nxt = E_BAD_BYTE;
          end
          M_ZERO, M_INT: begin
            if (ch == ".") mode_nxt = M_FRAC0;
            else if (q_data.expch) mode_nxt = M_EXP0;
          end
          M_FRAC0: if (q_data.digit) mode_nxt = M_FRAC; else err_nxt = E_BAD_BYTE;
          M_FRAC: if (q_data.expch) mode_nxt = M_EXP0;
          M_EXP0: begin
            if (ch == "+" || ch == "-") mode_nxt = M_EXPS;
            else if (q_data.digit) mode_nxt = M_EXP;
            else err_nxt = E_BAD_BYTE;
          end
          M_EXPS: if (q_data.digit) mode_nxt = M_EXP; else err_nxt = E_BAD_BYTE;
          M_EXP: ;
          default: err_nxt = E_BAD_BYTE;
        endcase
        // first error freezes the parse state as it was before this byte
        if (err_nxt != E_NONE) begin
          eoff_nxt = off_r;
          stk_nxt = stk_r; lvl_nxt = lvl_r; sub_nxt = sub_r; lsel_nxt = lsel_r;
          key_nxt = key_r; tok_nxt = tok_r;
          mode_nxt = m;
        end
      end
    end
    complete = (mode_nxt == M_DONE) || (lvl_nxt == '0 &&
               (mode_nxt == M_ZERO || mode_nxt == M_INT ||
                mode_nxt == M_FRAC || mode_nxt == M_EXP));
  end

  always_ff @(posedge clk) begin
    if (take && q_data.last) begin
      res_accepted <= (err_nxt == E_NONE) && complete;
      if (err_nxt != E_NONE) begin
        res_code <= err_nxt; res_offset <= 21'(eoff_nxt);
      end else if (!complete) begin
        res_code <= E_TRUNC;
        res_offset <= 21'((off_r < OFF_MAX) ? off_r + OW'(1) : off_r);
      end else begin
        res_code <= E_NONE; res_offset <= '0;
      end
      res_tokens <= 16'(tok_nxt);
    end
    if (!rst_n) begin
      max_nest_r <= 7'd64; max_tok_r <= 16'd32768; req_obj_r <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_NESTING:    max_nest_r <= cfg_wdata[6:0];
          CFG_MAX_TOKENS:     max_tok_r <= cfg_wdata;
          CFG_REQUIRE_OBJECT: req_obj_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (take && q_data.last) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
    // stack entries are always pushed before they are read, so no clearing
    if (rst_n && take && !q_data.last) stk_r <= stk_nxt;
    if (!rst_n || (take && q_data.last)) begin
      lvl_r <= '0; mode_r <= M_VALUE; sub_r <= '0; lsel_r <= '0;
      key_r <= 1'b0; tok_r <= '0; off_r <= '0; err_r <= E_NONE; eoff_r <= '0;
    end else if (take) begin
      lvl_r <= lvl_nxt; mode_r <= mode_nxt; sub_r <= sub_nxt;
      lsel_r <= lsel_nxt; key_r <= key_nxt; tok_r <= tok_nxt;
      err_r <= err_nxt; eoff_r <= eoff_nxt;
      if (off_r < OFF_MAX) off_r <= off_r + OW'(1);
    end
  end
endmodule
`default_nettype wire

/* sv/strict_json_validator.sv */
// strict json validator: one document byte per cycle while no result waits to be taken
// result: the last byte passes the front queue, then the back registers the result
// throughput: one byte per cycle while no result waits, set by the parser step in the back
// stalls: a waiting result holds the back; the two-entry queue fills, then input ready drops
// reset: synchronous active-low; registers return to their defaults, document state clears
`default_nettype none
module strict_json_validator import sjv_pkg::*; #(
  parameter int STACK_LEVELS  = 65,
  parameter int MAX_DOC_BYTES = 1048576,
  parameter int TOKEN_LIMIT   = 32768
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sjv_in_if.sink    in_ch,
  sjv_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  cls_t q_data;
  logic q_valid, q_ready;

  sjv_front u_front (
    .clk, .rst_n,
    .in_byte(in_ch.doc_byte), .in_last(in_ch.end_of_doc),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .q_data, .q_valid, .q_ready
  );

  sjv_back #(
    .STACK_LEVELS(STACK_LEVELS), .MAX_DOC_BYTES(MAX_DOC_BYTES), .TOKEN_LIMIT(TOKEN_LIMIT)
  ) u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_ready,
    .cfg_we, .cfg_index, .cfg_wdata,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_accepted(out_ch.accepted), .res_code(out_ch.error_code),
    .res_offset(out_ch.error_offset), .res_tokens(out_ch.token_count)
  );

  a_acc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.accepted == (out_ch.error_code == E_NONE)))
    else $error("accepted flag disagrees with error code");
  a_acc_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.accepted) |-> (out_ch.error_offset == '0))
    else $error("offset set on accepted document");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped while stalled");
endmodule
`default_nettype wire

/* dv/strict_json_validator_tb.sv */
// self-checking testbench for strict_json_validator: byte stream driver, result monitor
// and a local syntax predictor; depends on sjv_pkg, sjv_if.sv and the validator rtl
`default_nettype none
module strict_json_validator_tb;
  import sjv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_LV  = 65;
  localparam int MAX_BYTES = 1048576;
  localparam int TOK_LIM   = 32768;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } doc_item_t;

  typedef struct {
    logic        accepted;
    logic [3:0]  code;
    logic [20:0] offset;
    logic [15:0] tokens;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  sjv_in_if  in_ch ();
  sjv_out_if out_ch ();

  strict_json_validator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  doc_item_t pending_bytes[$];
  verdict_t  expected_verdicts[$];
  logic [7:0] doc_buf[$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  bit  took = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;

  // predictor state
  int unsigned p_nest, p_tok, p_req;
  bit [STACK_LV-1:0] p_stack;
  int unsigned p_level, p_sub, p_lit, p_tokens, p_off, p_err_off;
  mode_t p_mode;
  bit p_key;
  logic [3:0] p_err;
  string lit_words[3] = '{"true", "false", "null"};

  function automatic bit is_ws(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hexch(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function void clear_doc();
    p_stack = '0; p_level = 0; p_mode = M_VALUE; p_sub = 0; p_lit = 0;
    p_key = 1'b0; p_tokens = 0; p_off = 0; p_err = E_NONE; p_err_off = 0;
  endfunction

  function void flag(logic [3:0] code);
    if (p_err == E_NONE) begin
      p_err = code;
      p_err_off = p_off;
    end
  endfunction

  function bit room_for_value();
    int unsigned nest, tok;
    nest = (p_nest < STACK_LV - 1) ? p_nest : STACK_LV - 1;
    tok = (p_tok < TOK_LIM) ? p_tok : TOK_LIM;
    if (p_level > nest) begin
      flag(E_DEEP);
      return 1'b0;
    end
    if (p_tokens >= tok) begin
      flag(E_TOKENS);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void finish_value();
    p_mode = (p_level != 0) ? M_AFTER : M_DONE;
  endfunction

  function void close_level(logic [7:0] c);
    bit want;
    want = (c == "}");
    if (p_level == 0 || p_stack[p_level-1] != want) begin
      flag(E_BAD_BYTE);
      return;
    end
    p_level--;
    finish_value();
  endfunction

  function void open_key();
    if (!room_for_value()) return;
    p_tokens++;
    p_key = 1'b1;
    p_mode = M_STR;
  endfunction

  function void open_value(logic [7:0] c);
    if (!room_for_value()) return;
    if (!(c == "{" || c == "[" || c == "\"" || c == "t" || c == "f" || c == "n" ||
          c == "-" || is_dig(c))) begin
      flag(E_BAD_BYTE);
      return;
    end
    if (p_level == 0 && p_req != 0 && c != "{") begin
      flag(E_NOT_OBJ);
      return;
    end
    p_tokens++;
    if (c == "{" || c == "[") begin
      p_stack[p_level] = (c == "{");
      p_level++;
      p_mode = (c == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
    end else if (c == "\"") begin
      p_key = 1'b0;
      p_mode = M_STR;
    end else if (c == "t" || c == "f" || c == "n") begin
      p_lit = (c == "t") ? 0 : (c == "f") ? 1 : 2;
      p_sub = 1;
      p_mode = M_LIT;
    end else if (c == "-") p_mode = M_NEG;
    else if (c == "0") p_mode = M_ZERO;
    else p_mode = M_INT;
  endfunction

  // returns one when the byte has to be seen again in the new mode
  function bit parse_byte(logic [7:0] c);
    case (p_mode)
      M_VALUE: if (!is_ws(c)) open_value(c);
      M_ARR_FIRST: begin
        if (!is_ws(c)) begin
          if (c == "]") close_level(c);
          else open_value(c);
        end
      end
      M_OBJ_FIRST, M_KEY: begin
        if (!is_ws(c)) begin
          if (c == "}" && p_mode == M_OBJ_FIRST) close_level(c);
          else if (c == "\"") open_key();
          else flag(E_BAD_BYTE);
        end
      end
      M_COLON: begin
        if (!is_ws(c)) begin
          if (c == ":") p_mode = M_VALUE;
          else flag(E_BAD_BYTE);
        end
      end
      M_AFTER: begin
        if (!is_ws(c)) begin
          if (c == "," && p_level > 0) p_mode = p_stack[p_level-1] ? M_KEY : M_VALUE;
          else if (c == "}" || c == "]") close_level(c);
          else flag(E_BAD_BYTE);
        end
      end
      M_DONE: if (!is_ws(c)) flag(E_TRAIL);
      M_STR: begin
        if (c < 8'd32) flag(E_CTRL);
        else if (c == "\"") begin
          if (p_key) p_mode = M_COLON;
          else finish_value();
        end else if (c == "\\") p_mode = M_ESC;
      end
      M_ESC: begin
        if (c == "u") begin
          p_sub = 0;
          p_mode = M_HEX;
        end else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                     c == "n" || c == "r" || c == "t") p_mode = M_STR;
        else flag(E_ESCAPE);
      end
      M_HEX: begin
        if (!is_hexch(c)) flag(E_ESCAPE);
        else begin
          p_sub++;
          if (p_sub >= 4) p_mode = M_STR;
        end
      end
      M_LIT: begin
        if (c != lit_words[p_lit][p_sub]) flag(E_BAD_BYTE);
        else begin
          p_sub++;
          if (p_sub >= lit_words[p_lit].len()) finish_value();
        end
      end
      M_NEG: begin
        if (c == "0") p_mode = M_ZERO;
        else if (is_dig(c)) p_mode = M_INT;
        else flag(E_BAD_BYTE);
      end
      M_ZERO, M_INT: begin
        if (p_mode == M_INT && is_dig(c)) return 1'b0;
        if (c == ".") p_mode = M_FRAC0;
        else if (c == "e" || c == "E") p_mode = M_EXP0;
        else begin
          finish_value();
          return 1'b1;
        end
      end
      M_FRAC0: begin
        if (is_dig(c)) p_mode = M_FRAC;
        else flag(E_BAD_BYTE);
      end
      M_FRAC: begin
        if (is_dig(c)) return 1'b0;
        if (c == "e" || c == "E") p_mode = M_EXP0;
        else begin
          finish_value();
          return 1'b1;
        end
      end
      M_EXP0: begin
        if (c == "+" || c == "-") p_mode = M_EXPS;
        else if (is_dig(c)) p_mode = M_EXP;
        else flag(E_BAD_BYTE);
      end
      M_EXPS: begin
        if (is_dig(c)) p_mode = M_EXP;
        else flag(E_BAD_BYTE);
      end
      M_EXP: begin
        if (is_dig(c)) return 1'b0;
        finish_value();
        return 1'b1;
      end
      default: flag(E_BAD_BYTE);
    endcase
    return 1'b0;
  endfunction

  function void predict_byte(logic [7:0] c, logic last);
    bit done;
    verdict_t v;
    if (p_err == E_NONE) begin
      if (p_off >= MAX_BYTES) flag(E_LONG);
      else if (parse_byte(c) && p_err == E_NONE) void'(parse_byte(c));
    end
    if (p_off < MAX_BYTES) p_off++;
    if (!last) return;
    done = p_mode == M_DONE || (p_level == 0 && (p_mode == M_ZERO || p_mode == M_INT ||
                                                 p_mode == M_FRAC || p_mode == M_EXP));
    if (p_err == E_NONE && !done) flag(E_TRUNC);
    v.accepted = (p_err == E_NONE);
    v.code = p_err;
    v.offset = (p_err != E_NONE) ? p_err_off[20:0] : 21'd0;
    v.tokens = p_tokens[15:0];
    expected_verdicts.push_back(v);
    clear_doc();
  endfunction

  // stimulus builders
  function void put_ws();
    if ($urandom_range(0, 3) == 0) doc_buf.push_back(" ");
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: doc_buf.push_back(8'h09);
        1: doc_buf.push_back(8'h0d);
        default: doc_buf.push_back(8'h0a);
      endcase
    end
  endfunction

  function void put_text(string s);
    for (int i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
  endfunction

  function void put_string();
    string hexd = "0123456789abcdefABCDEF";
    string esc = "\"\\/bfnrt";
    int n;
    n = $urandom_range(0, 5);
    doc_buf.push_back("\"");
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          doc_buf.push_back("\\");
          doc_buf.push_back(esc[$urandom_range(0, 7)]);
        end
        1: begin
          doc_buf.push_back("\\");
          doc_buf.push_back("u");
          repeat (4) doc_buf.push_back(hexd[$urandom_range(0, 21)]);
        end
        2: doc_buf.push_back(8'($urandom_range(128, 255)));
        default: doc_buf.push_back(8'($urandom_range(32, 126)) == "\"" ? "q" :
                                   8'($urandom_range(32, 126)) == "\\" ? "s" : "a");
      endcase
    end
    doc_buf.push_back("\"");
  endfunction

  function void put_number();
    if ($urandom_range(0, 2) == 0) doc_buf.push_back("-");
    if ($urandom_range(0, 3) == 0) doc_buf.push_back("0");
    else begin
      doc_buf.push_back(8'($urandom_range("1", "9")));
      repeat ($urandom_range(0, 3)) doc_buf.push_back(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 2) == 0) begin
      doc_buf.push_back(".");
      repeat ($urandom_range(1, 3)) doc_buf.push_back(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 3) == 0) begin
      doc_buf.push_back($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: doc_buf.push_back("+");
        1: doc_buf.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) doc_buf.push_back(8'($urandom_range("0", "9")));
    end
  endfunction

  function automatic void put_value(int depth, bit top_obj);
    int kind, n;
    kind = top_obj ? 0 : (depth >= 3) ? $urandom_range(2, 4) : $urandom_range(0, 4);
    case (kind)
      0: begin
        doc_buf.push_back("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i != 0) doc_buf.push_back(",");
          put_ws();
          put_string();
          put_ws();
          doc_buf.push_back(":");
          put_ws();
          put_value(depth + 1, 1'b0);
          put_ws();
        end
        doc_buf.push_back("}");
      end
      1: begin
        doc_buf.push_back("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i != 0) doc_buf.push_back(",");
          put_ws();
          put_value(depth + 1, 1'b0);
          put_ws();
        end
        doc_buf.push_back("]");
      end
      2: put_string();
      3: put_number();
      default: put_text(lit_words[$urandom_range(0, 2)]);
    endcase
  endfunction

  function void send_doc();
    doc_item_t it;
    for (int i = 0; i < doc_buf.size(); i++) begin
      it.b = doc_buf[i];
      it.last = (i == doc_buf.size() - 1);
      pending_bytes.push_back(it);
    end
    doc_buf.delete();
  endfunction

  function void send_random_doc();
    int k;
    if ($urandom_range(0, 9) == 0) begin
      // raw noise
      repeat ($urandom_range(1, 8)) doc_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_ws();
      put_value(0, $urandom_range(0, 9) < 7);
      put_ws();
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, doc_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: doc_buf[k] = 8'($urandom_range(0, 255));
          1: while (doc_buf.size() > k + 1) void'(doc_buf.pop_back());
          2: doc_buf.push_back(8'($urandom_range(33, 126)));
          default: doc_buf.insert(k, ",");
        endcase
      end
    end
    send_doc();
  endfunction

  function void send_directed();
    string docs[$];
    docs = '{"{}", "[]", " { \"a\" : [1,-0.5e+3,2E-7,true,false,null,\"x\\u00aF\\n\"] } ",
             "{\"a\":1,}", "[1,]", "{1:2}", "{\"a\" 1}", "\"\001\"", "\"\\x\"",
             "\"\\\001\"", "\"\\u12G4\"", "{\"a\":tru}", "01", "1.", "1e", "-",
             "{} x", "{", "1", "{\"k\":\"\377\"}", "[}"};
    foreach (docs[i]) begin
      put_text(docs[i]);
      send_doc();
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      CFG_MAX_NESTING:    p_nest = val[6:0];
      CFG_MAX_TOKENS:     p_tok = val;
      CFG_REQUIRE_OBJECT: p_req = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_docs(int nbytes);
    int start;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < nbytes) send_random_doc();
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_ch.valid && !took)) begin
        if (took) begin
          void'(pending_bytes.pop_front());
          took = 1'b0;
        end
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (!calm && pending_bytes.size() != 0 && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 3);
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.doc_byte <= pending_bytes[0].b;
          in_ch.end_of_doc <= pending_bytes[0].last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitors
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_byte(in_ch.doc_byte, in_ch.end_of_doc);
      took = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: acc %0b code %0d",
                                       out_ch.accepted, out_ch.error_code);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_ch.accepted !== want.accepted || out_ch.error_code !== want.code ||
            out_ch.error_offset !== want.offset || out_ch.token_count !== want.tokens) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp acc %0b code %0d off %0d tok %0d, got %0b %0d %0d %0d",
                     want.accepted, want.code, want.offset, want.tokens, out_ch.accepted,
                     out_ch.error_code, out_ch.error_offset, out_ch.token_count);
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_NESTING;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.doc_byte = '0;
    in_ch.end_of_doc = 1'b0;
    out_ch.ready = 1'b0;
    p_nest = 64; p_tok = 32768; p_req = 1;
    clear_doc();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_directed();
    drain();

    write_reg(CFG_REQUIRE_OBJECT, 16'd0);
    send_directed();
    // nesting past the limit
    repeat (66) doc_buf.push_back("[");
    repeat (66) doc_buf.push_back("]");
    send_doc();
    random_docs(350);
    drain();

    write_reg(CFG_MAX_NESTING, 16'd0);
    write_reg(CFG_MAX_TOKENS, 16'd1);
    random_docs(250);
    drain();

    write_reg(CFG_MAX_NESTING, 16'd127);
    write_reg(CFG_MAX_TOKENS, 16'd0);
    write_reg(2'd3, 16'hffff);
    random_docs(200);
    drain();

    write_reg(CFG_MAX_NESTING, 16'd2);
    write_reg(CFG_MAX_TOKENS, 16'd5);
    write_reg(CFG_REQUIRE_OBJECT, 16'd1);
    random_docs(350);
    drain();

    write_reg(CFG_MAX_NESTING, 16'd64);
    write_reg(CFG_MAX_TOKENS, 16'd65535);
    random_docs(300);
    calm = 1'b1;
    random_docs(150);
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
sv/sjv_pkg.sv
sv/sjv_if.sv
sv/sjv_front.sv
sv/sjv_back.sv
sv/strict_json_validator.sv
dv/strict_json_validator_tb.sv
